// ===== rtl/core/bmp_stream_to_rgb565_canvas_assert.svh =====
// Assertion macros used by the canvas decoder checker.
`ifndef BMP_STREAM_TO_RGB565_CANVAS_ASSERT_SVH
`define BMP_STREAM_TO_RGB565_CANVAS_ASSERT_SVH

// Clocked check, switched off while reset is high.
`define BMPC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define BMPC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bmpc_pkg.sv =====
// Shared types, constants and sizes for the BMP to RGB565 canvas decoder.
package bmpc_pkg;

  localparam int CANVAS_W      = 128;
  localparam int CANVAS_H      = 128;
  localparam int MAX_ROW_BYTES = 1024;

  localparam int ADDR_W  = 14;
  localparam int VALUE_W = 16;
  localparam int ROW_W   = $clog2(CANVAS_H);
  localparam int COL_W   = $clog2(CANVAS_W);
  localparam int BIR_W   = $clog2(MAX_ROW_BYTES);
  localparam int CB_W    = $clog2(3 * CANVAS_W + 1);
  localparam int PROD_W  = $clog2(CANVAS_W * CANVAS_H);
  localparam int ADDR_EXT_W = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // header layout
  localparam logic [31:0] HDR_LEN    = 32'd54;
  localparam logic [31:0] HDR_LAST   = 32'd53;
  localparam logic [31:0] POS_TAG0   = 32'd0;
  localparam logic [31:0] POS_TAG1   = 32'd1;
  localparam logic [31:0] OFF_DATA   = 32'd10;
  localparam logic [31:0] OFF_WIDTH  = 32'd18;
  localparam logic [31:0] OFF_HEIGHT = 32'd22;
  localparam logic [31:0] OFF_BITS   = 32'd28;
  localparam logic [31:0] OFF_COMP   = 32'd30;
  localparam logic [31:0] LEN_WORD   = 32'd4;
  localparam logic [31:0] LEN_HALF   = 32'd2;

  localparam logic [7:0]  TAG_B = 8'h42;
  localparam logic [7:0]  TAG_M = 8'h4D;
  localparam logic [15:0] BITS_16 = 16'd16;
  localparam logic [15:0] BITS_24 = 16'd24;
  localparam logic [31:0] COMP_RGB       = 32'd0;
  localparam logic [31:0] COMP_BITFIELDS = 32'd3;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_BMP     = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_TOO_WIDE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD_LO,
    OP_LOAD_HI,
    OP_WR16,
    OP_WR24
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [ROW_W-1:0] crow;
    logic [COL_W-1:0] col;
    logic             clr;
    logic             done;
    status_t          status;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/core/bmpc_queue.sv =====
// Short FIFO of classified items between the front and back parts.
module bmpc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bmpc_pkg::q_item_t   push_item,
  input  logic                pop,
  output bmpc_pkg::q_item_t   pop_item,
  output bmpc_pkg::q_status_t status
);

  bmpc_pkg::q_item_t                 slots [bmpc_pkg::QUEUE_DEPTH];
  logic [bmpc_pkg::QPTR_W-1:0]       wr_ptr;
  logic [bmpc_pkg::QPTR_W-1:0]       rd_ptr;
  logic [bmpc_pkg::QCNT_W-1:0]       count;
  logic                              do_push;
  logic                              do_pop;

  localparam logic [bmpc_pkg::QPTR_W-1:0] PTR_LAST = bmpc_pkg::QPTR_W'(bmpc_pkg::QUEUE_DEPTH - 1);
  localparam logic [bmpc_pkg::QCNT_W-1:0] CNT_FULL = bmpc_pkg::QCNT_W'(bmpc_pkg::QUEUE_DEPTH);

  assign status.full  = (count == CNT_FULL);
  assign status.empty = (count == '0);
  assign do_push  = push && !status.full;
  assign do_pop   = pop && !status.empty;
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/core/bmpc_front.sv =====
// Front part: header capture, geometry, row and column tracking, item classification.
module bmpc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,  // [7:0] file_byte
  input  logic              s_axis_tlast,  // last_byte
  input  logic              full,
  output logic              push,
  output bmpc_pkg::q_item_t item
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_GAP,
    PH_PIXELS,
    PH_IDLE
  } phase_t;

  phase_t                          phase, phase_next;
  logic [31:0]                     pos, pos_next;
  logic [31:0]                     data_start, data_start_next;
  logic [31:0]                     img_w, img_w_next;
  logic [31:0]                     img_h, img_h_next;
  logic [15:0]                     bits, bits_next;
  logic [31:0]                     comp, comp_next;
  bmpc_pkg::status_t               err, err_next;
  logic [bmpc_pkg::BIR_W-1:0]      byte_in_row, byte_in_row_next;
  logic [1:0]                      k, k_next;
  logic [bmpc_pkg::COL_W-1:0]      pix_col, pix_col_next;
  logic [31:0]                     crow, crow_next;
  logic [31:0]                     rows_left, rows_left_next;

  // geometry pipeline, settles while the rest of the header streams in
  logic                            s1_is16, s1_ok, s1_flip;
  logic [30:0]                     s1_w;
  logic [31:0]                     s1_h_abs;
  logic                            s2_too_wide, s2_clr, s2_h_zero;
  logic [bmpc_pkg::BIR_W-1:0]      s2_row_last;
  logic [bmpc_pkg::COL_W-1:0]      s2_off_x;
  logic [bmpc_pkg::ROW_W-1:0]      s2_off_y;
  logic [bmpc_pkg::CB_W-1:0]       s2_copy_bytes;
  logic [31:0]                     s2_rows_last;
  logic [31:0]                     s3_crow_start;

  logic                            accept;
  logic [7:0]                      b;
  logic                            is16_c, is24_c, neg_h_c;
  logic [33:0]                     w34, wb, rs, rs_m1;
  logic                            w_lt_cw, h_lt_ch;
  logic [bmpc_pkg::COL_W:0]        dx, copy_w;
  logic [bmpc_pkg::ROW_W:0]        dy;
  logic [bmpc_pkg::CB_W-1:0]       cw_ext;
  logic                            in_pixels, active;
  logic [1:0]                      k_max;

  localparam logic [bmpc_pkg::COL_W:0] CW_EXT = (bmpc_pkg::COL_W + 1)'(bmpc_pkg::CANVAS_W);
  localparam logic [bmpc_pkg::ROW_W:0] CH_EXT = (bmpc_pkg::ROW_W + 1)'(bmpc_pkg::CANVAS_H);

  assign s_axis_tready = !full;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign b = s_axis_tdata;

  // stage 1: format and signs
  always_comb begin
    is16_c  = (bits == bmpc_pkg::BITS_16) && (comp == bmpc_pkg::COMP_BITFIELDS);
    is24_c  = (bits == bmpc_pkg::BITS_24) && (comp == bmpc_pkg::COMP_RGB);
    neg_h_c = img_h[31];
  end

  // stage 2: row size, centring offsets, clipping
  always_comb begin
    w34     = {3'b000, s1_w};
    wb      = (w34 << 1) + (s1_is16 ? 34'd0 : w34);
    rs      = (wb + 34'd3) & ~34'd3;
    rs_m1   = rs - 34'd1;
    w_lt_cw = s1_w < 31'(bmpc_pkg::CANVAS_W);
    h_lt_ch = s1_h_abs < 32'(bmpc_pkg::CANVAS_H);
    dx      = CW_EXT - s1_w[bmpc_pkg::COL_W:0];
    dy      = CH_EXT - s1_h_abs[bmpc_pkg::ROW_W:0];
    copy_w  = w_lt_cw ? s1_w[bmpc_pkg::COL_W:0] : CW_EXT;
    cw_ext  = bmpc_pkg::CB_W'(copy_w);
  end

  always_ff @(posedge clk) begin
    s1_is16  <= is16_c;
    s1_ok    <= (is16_c || is24_c) && (img_w != 32'd0) && !img_w[31];
    s1_w     <= img_w[30:0];
    s1_h_abs <= neg_h_c ? (32'd0 - img_h) : img_h;
    s1_flip  <= !neg_h_c && (img_h != 32'd0);

    s2_too_wide   <= rs > 34'(bmpc_pkg::MAX_ROW_BYTES);
    s2_row_last   <= rs_m1[bmpc_pkg::BIR_W-1:0];
    s2_off_x      <= w_lt_cw ? dx[bmpc_pkg::COL_W:1] : '0;
    s2_off_y      <= h_lt_ch ? dy[bmpc_pkg::ROW_W:1] : '0;
    s2_copy_bytes <= (cw_ext << 1) + (s1_is16 ? '0 : cw_ext);
    s2_clr        <= w_lt_cw || h_lt_ch;
    s2_h_zero     <= (s1_h_abs == 32'd0);
    s2_rows_last  <= s1_h_abs - 32'd1;

    s3_crow_start <= 32'(s2_off_y) + (s1_flip ? s2_rows_last : 32'd0);
  end

  always_comb begin
    phase_next       = phase;
    pos_next         = pos;
    data_start_next  = data_start;
    img_w_next       = img_w;
    img_h_next       = img_h;
    bits_next        = bits;
    comp_next        = comp;
    err_next         = err;
    byte_in_row_next = byte_in_row;
    k_next           = k;
    pix_col_next     = pix_col;
    crow_next        = crow;
    rows_left_next   = rows_left;
    item             = '0;
    item.op          = bmpc_pkg::OP_NONE;
    item.status      = bmpc_pkg::ST_OK;
    in_pixels        = 1'b0;
    active           = 1'b0;
    k_max            = s1_is16 ? 2'd1 : 2'd2;
    push             = 1'b0;

    if (accept) begin
      unique case (phase) inside
        PH_HEADER: begin
          if ((pos == bmpc_pkg::POS_TAG0 && b != bmpc_pkg::TAG_B) ||
              (pos == bmpc_pkg::POS_TAG1 && b != bmpc_pkg::TAG_M)) begin
            err_next   = bmpc_pkg::ST_NOT_BMP;
            phase_next = PH_IDLE;
          end else begin
            if (pos >= bmpc_pkg::OFF_DATA && pos < bmpc_pkg::OFF_DATA + bmpc_pkg::LEN_WORD) begin
              data_start_next[{2'(pos - bmpc_pkg::OFF_DATA), 3'b000} +: 8] = b;
            end
            if (pos >= bmpc_pkg::OFF_WIDTH &&
                pos < bmpc_pkg::OFF_WIDTH + bmpc_pkg::LEN_WORD) begin
              img_w_next[{2'(pos - bmpc_pkg::OFF_WIDTH), 3'b000} +: 8] = b;
            end
            if (pos >= bmpc_pkg::OFF_HEIGHT &&
                pos < bmpc_pkg::OFF_HEIGHT + bmpc_pkg::LEN_WORD) begin
              img_h_next[{2'(pos - bmpc_pkg::OFF_HEIGHT), 3'b000} +: 8] = b;
            end
            if (pos >= bmpc_pkg::OFF_BITS && pos < bmpc_pkg::OFF_BITS + bmpc_pkg::LEN_HALF) begin
              bits_next[{1'(pos - bmpc_pkg::OFF_BITS), 3'b000} +: 8] = b;
            end
            if (pos >= bmpc_pkg::OFF_COMP && pos < bmpc_pkg::OFF_COMP + bmpc_pkg::LEN_WORD) begin
              comp_next[{2'(pos - bmpc_pkg::OFF_COMP), 3'b000} +: 8] = b;
            end
            if (pos == bmpc_pkg::HDR_LAST) begin
              if (!s1_ok) begin
                err_next   = bmpc_pkg::ST_UNSUPPORTED;
                phase_next = PH_IDLE;
              end else if (s2_too_wide) begin
                err_next   = bmpc_pkg::ST_TOO_WIDE;
                phase_next = PH_IDLE;
              end else begin
                item.clr = s2_clr;
                if (data_start < bmpc_pkg::HDR_LEN) begin
                  data_start_next = bmpc_pkg::HDR_LEN;
                end
                phase_next       = s2_h_zero ? PH_IDLE : PH_GAP;
                byte_in_row_next = '0;
                k_next           = '0;
                pix_col_next     = s2_off_x;
                crow_next        = s3_crow_start;
                rows_left_next   = s2_rows_last;
              end
            end
          end
        end
        PH_GAP, PH_PIXELS: begin
          in_pixels = (phase == PH_PIXELS) || (pos >= data_start);
          if (in_pixels) begin
            phase_next = PH_PIXELS;
            active = (crow < 32'(bmpc_pkg::CANVAS_H)) &&
                     (32'(byte_in_row) < 32'(s2_copy_bytes));
            if (active) begin
              item.data = b;
              item.crow = crow[bmpc_pkg::ROW_W-1:0];
              item.col  = pix_col;
              if (k == 2'd0) begin
                item.op = bmpc_pkg::OP_LOAD_LO;
              end else if (s1_is16) begin
                item.op = bmpc_pkg::OP_WR16;
              end else if (k == 2'd1) begin
                item.op = bmpc_pkg::OP_LOAD_HI;
              end else begin
                item.op = bmpc_pkg::OP_WR24;
              end
            end
            if (byte_in_row == s2_row_last) begin
              byte_in_row_next = '0;
              k_next           = '0;
              pix_col_next     = s2_off_x;
              crow_next        = s1_flip ? crow - 32'd1 : crow + 32'd1;
              rows_left_next   = rows_left - 32'd1;
              if (rows_left == 32'd0) begin
                phase_next = PH_IDLE;
              end
            end else begin
              byte_in_row_next = byte_in_row + 1'b1;
              if (k == k_max) begin
                k_next       = '0;
                pix_col_next = pix_col + 1'b1;
              end else begin
                k_next = k + 1'b1;
              end
            end
          end
        end
        PH_IDLE: begin
        end
      endcase

      if (pos != '1) begin
        pos_next = pos + 32'd1;
      end

      if (s_axis_tlast) begin
        item.done = 1'b1;
        if (err_next != bmpc_pkg::ST_OK) begin
          item.status = err_next;
        end else if (phase_next == PH_HEADER) begin
          item.status = bmpc_pkg::ST_NOT_BMP;
        end
        // file ends: back to the state after reset
        phase_next       = PH_HEADER;
        pos_next         = '0;
        data_start_next  = '0;
        img_w_next       = '0;
        img_h_next       = '0;
        bits_next        = '0;
        comp_next        = '0;
        err_next         = bmpc_pkg::ST_OK;
        byte_in_row_next = '0;
        k_next           = '0;
      end

      push = (item.op != bmpc_pkg::OP_NONE) || item.clr || item.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      pos         <= '0;
      data_start  <= '0;
      img_w       <= '0;
      img_h       <= '0;
      bits        <= '0;
      comp        <= '0;
      err         <= bmpc_pkg::ST_OK;
      byte_in_row <= '0;
      k           <= '0;
    end else begin
      phase       <= phase_next;
      pos         <= pos_next;
      data_start  <= data_start_next;
      img_w       <= img_w_next;
      img_h       <= img_h_next;
      bits        <= bits_next;
      comp        <= comp_next;
      err         <= err_next;
      byte_in_row <= byte_in_row_next;
      k           <= k_next;
    end
    pix_col   <= pix_col_next;
    crow      <= crow_next;
    rows_left <= rows_left_next;
  end

endmodule

// ===== rtl/core/bmpc_back.sv =====
// Back part: pixel assembly, RGB565 packing, address forming and the output register.
module bmpc_back (
  input  logic                clk,
  input  logic                rst,
  input  bmpc_pkg::q_item_t   item,
  input  logic                empty,
  output logic                pop,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,  // [13:0] pixel_address, [29:14] pixel_value,
                                             // [31:30] status
  output logic [1:0]          m_axis_tuser,  // [0] pixel_write, [1] clear_canvas
  output logic                m_axis_tlast   // done_res
);

  localparam int ADDR_EXT_W_L = bmpc_pkg::ADDR_EXT_W;

  logic [7:0]                        lo;
  logic [7:0]                        hi;
  logic                              wr;
  logic                              produce;
  logic [ADDR_EXT_W_L-1:0]           prod;
  logic [bmpc_pkg::ADDR_W-1:0]       addr;
  logic [bmpc_pkg::VALUE_W-1:0]      value;

  assign pop = !empty && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    wr      = (item.op == bmpc_pkg::OP_WR16) || (item.op == bmpc_pkg::OP_WR24);
    produce = wr || item.clr || item.done;
    prod    = ADDR_EXT_W_L'(item.crow) * ADDR_EXT_W_L'(bmpc_pkg::CANVAS_W) +
              ADDR_EXT_W_L'(item.col);
    addr    = wr ? prod[bmpc_pkg::ADDR_W-1:0] : '0;
    case (item.op)
      bmpc_pkg::OP_WR16: value = {item.data, lo};
      bmpc_pkg::OP_WR24: value = {item.data[7:3], hi[7:2], lo[7:3]};
      default:           value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop) begin
      m_axis_tvalid <= produce;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (item.op == bmpc_pkg::OP_LOAD_LO) begin
        lo <= item.data;
      end
      if (item.op == bmpc_pkg::OP_LOAD_HI) begin
        hi <= item.data;
      end
      m_axis_tdata <= {item.status, value, addr};
      m_axis_tuser <= {item.clr, wr};
      m_axis_tlast <= item.done;
    end
  end

endmodule

// ===== rtl/core/bmp_stream_to_rgb565_canvas.sv =====
// Top level: BMP byte stream to RGB565 canvas writes.
// Throughput: one file byte per cycle, sustained; the front counters and the queue take a
// byte every cycle unless the queue is full.
// Path: the item for an accepted byte is written into the queue at the accepting edge and
// is loaded into the back part's output register when popped; output stalls hold it queued.
// Reset: synchronous, clears header capture, byte counters, queue and output valid at once.
module bmp_stream_to_rgb565_canvas (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] file_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [13:0] pixel_address, [29:14] pixel_value,
                                      // [31:30] status
  output logic [1:0]  m_axis_tuser,   // [0] pixel_write, [1] clear_canvas
  output logic        m_axis_tlast    // done_res
);

  bmpc_pkg::q_item_t   push_item;
  bmpc_pkg::q_item_t   pop_item;
  bmpc_pkg::q_status_t q_st;
  logic                push;
  logic                pop;

  bmpc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .full          (q_st.full),
    .push          (push),
    .item          (push_item)
  );

  bmpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_st)
  );

  bmpc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item          (pop_item),
    .empty         (q_st.empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== rtl/core/bmpc_checker.sv =====
// Port-level checks on the canvas decoder output stream, bound to the top level.
`include "bmp_stream_to_rgb565_canvas_assert.svh"

module bmpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled beat holds still
  `BMPC_ASSERT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output beat changed while stalled")

  `BMPC_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !m_axis_tvalid, "output valid after reset")

  // every beat is a write, a clear or the end status, and never write and clear together
  `BMPC_ASSERT(a_kind, clk, rst, m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tuser[1] || m_axis_tlast) && !(m_axis_tuser[0] && m_axis_tuser[1]), "empty or mixed output beat")

  // unused fields read as zero
  `BMPC_ASSERT(a_zero, clk, rst, m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tdata[29:0] == 30'd0) && (m_axis_tlast || m_axis_tdata[31:30] == 2'd0), "stray bits in unused fields")

endmodule

bind bmp_stream_to_rgb565_canvas bmpc_checker u_bmpc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
